// ===== design/bp128_block_unpacker_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the block unpacker
// Concurrent checks clocked on clk_i and held off while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef BP128_BLOCK_UNPACKER_DEFINES_SVH
`define BP128_BLOCK_UNPACKER_DEFINES_SVH

// The property must hold at every clock edge out of reset.
`define BPU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bpu_pkg.sv =====
// ---------------------------------------------------------------------------
// Block unpacker package
// Beat types, controller states and the command and status bundles.
// ---------------------------------------------------------------------------
package bpu_pkg;

  localparam int unsigned LANES           = 4;
  localparam int unsigned WORD_BITS       = 32;
  localparam int unsigned QUADS_PER_BLOCK = 32;
  localparam int unsigned COUNT_BITS      = 6;

  typedef struct packed {
    logic [31:0] lane_a;
    logic [31:0] lane_b;
    logic [31:0] lane_c;
    logic [31:0] lane_d;
    logic [5:0]  value_width;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value_a;
    logic [31:0] value_b;
    logic [31:0] value_c;
    logic [31:0] value_d;
    logic        block_end;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SPLIT,
    ST_RUN,
    ST_WRAP,
    ST_ZERO
  } state_e;

  typedef struct packed {
    logic load;
    logic split;
    logic run;
    logic zero;
    logic wrap;
  } cmd_t;

  typedef struct packed {
    logic width_zero;
    logic residue_any;
    logic fits;
    logic step_ok;
    logic quads_last;
  } stat_t;

endpackage

// ===== design/bp128_block_unpacker.sv =====
// ---------------------------------------------------------------------------
// Interleaved four-lane block unpacker
// Turns packed 128-bit words of a 128-value block back into quads of values.
// ---------------------------------------------------------------------------
// Input beats carry one packed word as four 32-bit lanes and the value width,
// which is read only on the first word of a block; a block of width W takes
// W words. Each output beat is one quad of values, block_end marks the 32nd.
// A width of zero takes one word, ignores its lanes and gives 32 zero quads.
// Words are handled one at a time by the controller: a word is taken only
// while the block is idle, so in_stall_o is high from the accept until the
// word's residue update, or for width zero its last zero quad, is done.
// A word's first quad passes the start state, then the split or run state
// that writes it into the output register. A word is worked in order:
// accept, start, an optional split quad, in-word quads at one quad per
// cycle while the output is not stalled, a step that finds the word end,
// and the residue update; a zero-width block gives its zero quads likewise.
// A stall on the output holds the current beat and pauses the quad loop.
// Reset clears the residue, the block counters and the latched width, and
// empties the output register.
// ---------------------------------------------------------------------------
module bp128_block_unpacker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bpu_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bpu_pkg::out_item_t  out_item_o
);

  bpu_pkg::cmd_t  cmd;
  bpu_pkg::stat_t stat;
  logic           in_ready;

  bpu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  bpu_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  assign in_stall_o = !in_ready;

endmodule

// ===== design/bpu_ctrl.sv =====
// ---------------------------------------------------------------------------
// Block unpacker controller
// Sequences one packed word: load, optional split quad, in-word quads, wrap; or load and zero quads.
// ---------------------------------------------------------------------------
module bpu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  bpu_pkg::stat_t  stat_i,
  output logic            in_ready_o,
  output bpu_pkg::cmd_t   cmd_o
);

  bpu_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpu_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bpu_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = bpu_pkg::ST_START;
      end
      bpu_pkg::ST_START: begin
        if (stat_i.width_zero) begin
          state_d = bpu_pkg::ST_ZERO;
        end else if (stat_i.residue_any) begin
          state_d = bpu_pkg::ST_SPLIT;
        end else begin
          state_d = bpu_pkg::ST_RUN;
        end
      end
      bpu_pkg::ST_SPLIT: begin
        if (stat_i.step_ok) state_d = bpu_pkg::ST_RUN;
      end
      bpu_pkg::ST_RUN: begin
        // Once the next value would cross the word end, its tail is residue.
        if (!stat_i.fits) state_d = bpu_pkg::ST_WRAP;
      end
      bpu_pkg::ST_WRAP: begin
        state_d = bpu_pkg::ST_IDLE;
      end
      bpu_pkg::ST_ZERO: begin
        if (stat_i.step_ok && stat_i.quads_last) state_d = bpu_pkg::ST_IDLE;
      end
      default: begin
        state_d = bpu_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == bpu_pkg::ST_IDLE);
    cmd_o       = '0;
    cmd_o.load  = in_ready_o && in_valid_i;
    cmd_o.split = (state_q == bpu_pkg::ST_SPLIT);
    cmd_o.run   = (state_q == bpu_pkg::ST_RUN) && stat_i.fits;
    cmd_o.zero  = (state_q == bpu_pkg::ST_ZERO);
    cmd_o.wrap  = (state_q == bpu_pkg::ST_WRAP);
  end

endmodule

// ===== design/bpu_datapath.sv =====
// ---------------------------------------------------------------------------
// Block unpacker datapath
// Word and residue registers, lane shifters, block counters, output register.
// ---------------------------------------------------------------------------
`include "bp128_block_unpacker_defines.svh"

module bpu_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bpu_pkg::in_item_t   in_item_i,
  input  bpu_pkg::cmd_t       cmd_i,
  input  logic                out_stall_i,
  output bpu_pkg::stat_t      stat_o,
  output logic                out_valid_o,
  output bpu_pkg::out_item_t  out_item_o
);

  localparam int unsigned CB = bpu_pkg::COUNT_BITS;

  logic [bpu_pkg::LANES-1:0][31:0] in_lanes;
  logic [bpu_pkg::LANES-1:0][31:0] word_q;
  logic [bpu_pkg::LANES-1:0][31:0] residue_q, residue_d;
  logic [bpu_pkg::LANES-1:0][31:0] vals;
  logic [4:0]    rbits_q, rbits_d;
  logic [CB-1:0] offset_q, offset_d;
  logic [CB-1:0] words_q, words_d;
  logic [CB-1:0] quads_q, quads_d;
  logic [CB-1:0] width_q, width_d;
  logic [CB-1:0] words_inc;
  logic [31:0]   mask;
  logic          out_valid_q, out_valid_d;
  bpu_pkg::out_item_t out_q;
  logic          quads_full;
  logic          step;
  logic          wr_out;
  logic          clear;

  assign in_lanes = {in_item_i.lane_d, in_item_i.lane_c, in_item_i.lane_b, in_item_i.lane_a};

  // A shift by the full word width leaves zero, so width 32 gives all ones.
  assign mask       = ~(32'hFFFF_FFFF << width_q);
  assign quads_full = (quads_q >= CB'(bpu_pkg::QUADS_PER_BLOCK));

  assign stat_o.width_zero  = (width_q == '0);
  assign stat_o.residue_any = (rbits_q != '0);
  assign stat_o.fits        = ({1'b0, offset_q} + {1'b0, width_q}) <= (CB + 1)'(bpu_pkg::WORD_BITS);
  assign stat_o.step_ok     = !out_valid_q || !out_stall_i || quads_full;
  assign stat_o.quads_last  = (quads_q == CB'(bpu_pkg::QUADS_PER_BLOCK - 1));

  assign step   = (cmd_i.split || cmd_i.run || cmd_i.zero) && stat_o.step_ok;
  assign wr_out = step && !quads_full;

  always_comb begin
    for (int k = 0; k < bpu_pkg::LANES; k++) begin
      if (cmd_i.zero) begin
        vals[k] = '0;
      end else if (cmd_i.split) begin
        vals[k] = (residue_q[k] | (word_q[k] << rbits_q)) & mask;
      end else begin
        vals[k] = (word_q[k] >> offset_q[4:0]) & mask;
      end
    end
  end

  assign words_inc = words_q + CB'(1);

  always_comb begin
    residue_d = residue_q;
    rbits_d   = rbits_q;
    offset_d  = offset_q;
    words_d   = words_q;
    quads_d   = quads_q;
    width_d   = width_q;
    clear     = 1'b0;

    if (cmd_i.load) begin
      offset_d = '0;
      if (words_q == '0) begin
        if (in_item_i.value_width > CB'(bpu_pkg::WORD_BITS)) begin
          width_d = CB'(bpu_pkg::WORD_BITS);
        end else begin
          width_d = in_item_i.value_width;
        end
      end
    end

    if (wr_out) quads_d = quads_q + CB'(1);

    if (step && cmd_i.split) offset_d = width_q - {1'b0, rbits_q};
    if (step && cmd_i.run)   offset_d = offset_q + width_q;
    if (step && cmd_i.zero && stat_o.quads_last) clear = 1'b1;

    if (cmd_i.wrap) begin
      if (offset_q < CB'(bpu_pkg::WORD_BITS)) begin
        for (int k = 0; k < bpu_pkg::LANES; k++) begin
          residue_d[k] = word_q[k] >> offset_q;
        end
        rbits_d = 5'(CB'(bpu_pkg::WORD_BITS) - offset_q);
      end else begin
        residue_d = '0;
        rbits_d   = '0;
      end
      words_d = words_inc;
      if (words_inc >= width_q) clear = 1'b1;
    end

    if (clear) begin
      residue_d = '0;
      rbits_d   = '0;
      words_d   = '0;
      quads_d   = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (wr_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      residue_q   <= '0;
      rbits_q     <= '0;
      offset_q    <= '0;
      words_q     <= '0;
      quads_q     <= '0;
      width_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      residue_q   <= residue_d;
      rbits_q     <= rbits_d;
      offset_q    <= offset_d;
      words_q     <= words_d;
      quads_q     <= quads_d;
      width_q     <= width_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) word_q <= in_lanes;
    if (wr_out) begin
      out_q.value_a   <= vals[0];
      out_q.value_b   <= vals[1];
      out_q.value_c   <= vals[2];
      out_q.value_d   <= vals[3];
      out_q.block_end <= stat_o.quads_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `BPU_ASSERT_NEXT(a_out_hold, out_valid_q && out_stall_i, out_valid_q && $stable(out_q), "stalled output beat was overwritten")
  `BPU_ASSERT(a_quads_bound, quads_q <= CB'(bpu_pkg::QUADS_PER_BLOCK), "more than one block of quads counted")
  `BPU_ASSERT(a_run_offset, !cmd_i.run || (offset_q < CB'(bpu_pkg::WORD_BITS)), "in-word quad taken past the word end")

endmodule
